// File: hdl/advection_flux_stencil_core_defines.svh
// ----------------------------------------------------------------------------
// advection flux stencil assertion macros
// shared concurrent check forms used by the stencil core
// ----------------------------------------------------------------------------
`ifndef ADVECTION_FLUX_STENCIL_CORE_DEFINES_SVH
`define ADVECTION_FLUX_STENCIL_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define AFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stencil core check failed");

// next-cycle implication, off during reset
`define AFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stencil core check failed");

`endif

// File: hdl/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// types, constants and helper functions of the advection flux stencil
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_ROW    = 512;
  localparam int WIN_DEPTH  = 2 * MAX_ROW;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int IDX_W      = 16;
  localparam int ROW_W      = 9;
  localparam int SPACE_W    = 31;
  localparam int REM_STEPS  = IDX_W;
  localparam int WIDE_W     = 68;

  // opcodes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // boundary codes
  localparam logic [1:0] BC_INTERIOR = 2'd0;
  localparam logic [1:0] BC_FIXED    = 2'd1;

  // register indexes
  localparam logic [1:0] CFG_ROW_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_CELL_COUNT = 2'd1;
  localparam logic [1:0] CFG_X_SPACING  = 2'd2;
  localparam logic [1:0] CFG_Y_SPACING  = 2'd3;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  // one line store entry
  typedef struct packed {
    logic [5:0] codes;
    val_t       accum;
    val_t       yvel;
    val_t       xvel;
    val_t       scalar;
  } win_word_t;

  localparam int WORD_W = $bits(win_word_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GHOST,
    S_CALC,
    S_DONE
  } state_t;

  // remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

  // saturate a wide signed value to the value range
  function automatic val_t sat_val(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((68'sd1 <<< (VALUE_BITS - 1)) - 68'sd1);
    lo = -hi - WIDE_W'(68'sd1);
    if (x > hi) begin
      sat_val = VALUE_BITS'(hi);
    end else if (x < lo) begin
      sat_val = VALUE_BITS'(lo);
    end else begin
      sat_val = VALUE_BITS'(x);
    end
  endfunction

  // ghost substitution for a boundary neighbour
  function automatic val_t ghost(input val_t nb, input val_t c, input logic [1:0] code);
    logic signed [WIDE_W-1:0] t;
    t = (WIDE_W'(nb) <<< 1) - WIDE_W'(c);
    case (code)
      BC_INTERIOR: ghost = nb;
      BC_FIXED:    ghost = sat_val(t);
      default:     ghost = c;
    endcase
  endfunction

endpackage

// File: hdl/afs_ram.sv
// ----------------------------------------------------------------------------
// afs_ram
// simple dual port line store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module afs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 134
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/afs_rem.sv
// ----------------------------------------------------------------------------
// afs_rem
// restoring remainder unit, one dividend bit per cycle, gives cell column
// ----------------------------------------------------------------------------
module afs_rem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [afs_pkg::IDX_W-1:0]    dividend,
  input  logic [afs_pkg::ROW_W-1:0]    divisor,
  output afs_pkg::rem_status_t         status,
  output logic [afs_pkg::ROW_W-1:0]    remainder
);

  localparam int CW = $clog2(afs_pkg::REM_STEPS + 1);

  logic [CW-1:0]                  count;
  logic [afs_pkg::IDX_W-1:0]      bits;
  logic [afs_pkg::ROW_W-1:0]      div;
  logic                           busy;
  logic                           done;
  logic [afs_pkg::ROW_W:0]        trial;

  // shift in next dividend bit
  assign trial = {remainder, bits[afs_pkg::IDX_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else if (busy) begin
      count <= count + CW'(1);
      if (count == CW'(afs_pkg::REM_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      bits      <= dividend;
      div       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      bits <= bits << 1;
      if (trial >= {1'b0, div}) begin
        remainder <= afs_pkg::ROW_W'(trial - {1'b0, div});
      end else begin
        remainder <= afs_pkg::ROW_W'(trial);
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: hdl/advection_flux_stencil_core.sv
// ----------------------------------------------------------------------------
// advection_flux_stencil_core
// central convective flux over a raster stream with a two-row line store
// ----------------------------------------------------------------------------
// Cells enter in raster order and are written to a 1024-entry line store. A
// cell's result leaves once its north neighbour has entered, or on a drain.
// An item that emits no result does not stall the input. An item that emits
// a result stalls the input until the block is idle again: the 16-step column
// remainder decides when, with the five line store reads (one port, one
// a cycle) and the eight steps on the shared 33x33 multiplier running beside
// it. A finished result sits in the output register while the next item is
// taken. Entries read before they are written in a frame feed only results that
// are forced to zero, so the store needs no clearing pass after reset.
module advection_flux_stencil_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [afs_pkg::SPACE_W-1:0]       cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic signed [31:0]                scalar_value,
  input  logic [1:0]                        scalar_code,
  input  logic signed [31:0]                xvel_value,
  input  logic [1:0]                        xvel_code,
  input  logic signed [31:0]                yvel_value,
  input  logic [1:0]                        yvel_code,
  input  logic signed [31:0]                accum_in,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       cell_index,
  output logic signed [31:0]                new_value,
  output logic                              edge_fault,
  output logic                              last_cell
);

  `include "advection_flux_stencil_core_defines.svh"

  localparam int IW = afs_pkg::IDX_W;
  localparam int AW = afs_pkg::WIN_AW;
  localparam int WW = afs_pkg::WIDE_W;

  afs_pkg::state_t state, state_next;

  // configuration registers
  logic [afs_pkg::ROW_W-1:0]   row_width;
  logic [IW-1:0]               cell_count;
  logic [afs_pkg::SPACE_W-1:0] x_spacing;
  logic [afs_pkg::SPACE_W-1:0] y_spacing;
  logic [afs_pkg::ROW_W-1:0]   w_eff;

  // frame counters
  logic [IW-1:0] arrived_count;
  logic [IW-1:0] emitted_count;
  logic          frame_clr;
  logic [IW-1:0] arr_e;
  logic [IW-1:0] emt_e;
  logic [IW-1:0] arr1;
  logic          data_take;
  logic          emit_go;
  logic          accept;
  logic          out_load;

  // per-result registers
  logic [IW-1:0]  cur_idx;
  logic [IW-1:0]  cur_arr;
  logic [2:0]     rcnt;
  logic [2:0]     kcnt;
  afs_pkg::win_word_t c_word, e_word, w_word, s_word, n_word;
  afs_pkg::val_t  pe, pw, pn, ps, ue, uw, vn, vs;
  afs_pkg::val_t  ew, ns, res_val;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] acc;
  logic signed [66:0] tsum;
  logic signed [66:0] diff;
  logic signed [66:0] rnd;
  logic signed [66:0] half;

  // memory ports
  logic               mem_we;
  logic [AW-1:0]      rd_addr;
  afs_pkg::win_word_t wr_word;
  afs_pkg::win_word_t rd_word;

  // column remainder
  afs_pkg::rem_status_t      rem_st;
  logic [afs_pkg::ROW_W-1:0] col;

  // fault check terms
  logic [IW:0] i_ext, i_p1, i_pw, n_ext, a_ext;
  logic        nb_ok;
  logic        interior;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= afs_pkg::ROW_W'(256);
      cell_count <= IW'(65535);
      x_spacing  <= afs_pkg::SPACE_W'(65536);
      y_spacing  <= afs_pkg::SPACE_W'(65536);
    end else if (cfg_write) begin
      case (cfg_index)
        afs_pkg::CFG_ROW_WIDTH:  row_width  <= cfg_data[afs_pkg::ROW_W-1:0];
        afs_pkg::CFG_CELL_COUNT: cell_count <= cfg_data[IW-1:0];
        afs_pkg::CFG_X_SPACING:  x_spacing  <= cfg_data;
        afs_pkg::CFG_Y_SPACING:  y_spacing  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (row_width == '0) ? afs_pkg::ROW_W'(1) : row_width;

  // admission decision
  assign accept    = in_valid && !in_stall;
  assign frame_clr = (emitted_count >= cell_count);
  assign arr_e     = frame_clr ? '0 : arrived_count;
  assign emt_e     = frame_clr ? '0 : emitted_count;
  assign data_take = (opcode == afs_pkg::OP_CELL) && (arr_e < cell_count);
  assign arr1      = data_take ? arr_e + IW'(1) : arr_e;
  always_comb begin
    if (opcode == afs_pkg::OP_CELL) begin
      emit_go = data_take && (({1'b0, emt_e} + (IW+1)'(w_eff)) < {1'b0, arr1});
    end else begin
      emit_go = (emt_e < arr_e);
    end
  end

  // line store
  assign mem_we          = accept && data_take;
  assign wr_word.codes   = {yvel_code, xvel_code, scalar_code};
  assign wr_word.accum   = accum_in;
  assign wr_word.yvel    = yvel_value;
  assign wr_word.xvel    = xvel_value;
  assign wr_word.scalar  = scalar_value;

  afs_ram #(
    .DEPTH (afs_pkg::WIN_DEPTH),
    .WIDTH (afs_pkg::WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (arr_e[AW-1:0]),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  afs_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && emit_go),
    .dividend  (emt_e),
    .divisor   (w_eff),
    .status    (rem_st),
    .remainder (col)
  );

  // neighbour read addresses: center, east, west, south, north
  always_comb begin
    case (rcnt)
      3'd0:    rd_addr = cur_idx[AW-1:0];
      3'd1:    rd_addr = cur_idx[AW-1:0] + AW'(1);
      3'd2:    rd_addr = cur_idx[AW-1:0] - AW'(1);
      3'd3:    rd_addr = cur_idx[AW-1:0] - AW'(w_eff);
      default: rd_addr = cur_idx[AW-1:0] + AW'(w_eff);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      afs_pkg::S_IDLE:  if (accept && emit_go) state_next = afs_pkg::S_READ;
      afs_pkg::S_READ:  if (rcnt == 3'd5) state_next = afs_pkg::S_GHOST;
      afs_pkg::S_GHOST: state_next = afs_pkg::S_CALC;
      afs_pkg::S_CALC:  if (kcnt == 3'd7) state_next = afs_pkg::S_DONE;
      afs_pkg::S_DONE:  if (out_load) state_next = afs_pkg::S_IDLE;
      default:          state_next = afs_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = (state != afs_pkg::S_IDLE);
    out_load = (state == afs_pkg::S_DONE) && rem_st.done && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      arrived_count <= '0;
      emitted_count <= '0;
    end else if (accept) begin
      arrived_count <= arr1;
      emitted_count <= emt_e;
      if (emit_go) begin
        emitted_count <= emt_e + IW'(1);
        if (({1'b0, emt_e} + (IW+1)'(1)) >= {1'b0, cell_count}) begin
          arrived_count <= '0;
          emitted_count <= '0;
        end
      end
    end
  end

  // sequence counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      kcnt <= '0;
    end else begin
      if (state == afs_pkg::S_IDLE) begin
        rcnt <= '0;
      end else if (state == afs_pkg::S_READ) begin
        rcnt <= rcnt + 3'd1;
      end
      if (state == afs_pkg::S_CALC) begin
        kcnt <= kcnt + 3'd1;
      end else begin
        kcnt <= '0;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (kcnt)
      3'd0:    begin mul_a = 33'(pe); mul_b = 33'(ue); end
      3'd1:    begin mul_a = 33'(pw); mul_b = 33'(uw); end
      3'd2:    begin mul_a = 33'(pn); mul_b = 33'(vn); end
      3'd3:    begin mul_a = 33'(ps); mul_b = 33'(vs); end
      3'd4:    begin mul_a = 33'(ew); mul_b = $signed({2'b00, y_spacing}); end
      default: begin mul_a = 33'(ns); mul_b = $signed({2'b00, x_spacing}); end
    endcase
  end

  // flux arithmetic
  assign diff = 67'(acc) - 67'(prod);
  assign rnd  = (diff + 67'sd32768) >>> 16;
  assign half = (tsum + 67'sd65536) >>> 17;

  always_ff @(posedge clk) begin
    if (accept && emit_go) begin
      cur_idx <= emt_e;
      cur_arr <= arr1;
    end
    // capture read data in the cycle after its address is presented
    if (state == afs_pkg::S_READ) begin
      case (rcnt)
        3'd1:    c_word <= rd_word;
        3'd2:    e_word <= rd_word;
        3'd3:    w_word <= rd_word;
        3'd4:    s_word <= rd_word;
        3'd5:    n_word <= rd_word;
        default: ;
      endcase
    end
    // ghost values
    if (state == afs_pkg::S_GHOST) begin
      pe <= afs_pkg::ghost(e_word.scalar, c_word.scalar, e_word.codes[1:0]);
      pw <= afs_pkg::ghost(w_word.scalar, c_word.scalar, w_word.codes[1:0]);
      pn <= afs_pkg::ghost(n_word.scalar, c_word.scalar, n_word.codes[1:0]);
      ps <= afs_pkg::ghost(s_word.scalar, c_word.scalar, s_word.codes[1:0]);
      ue <= afs_pkg::ghost(e_word.xvel, c_word.xvel, e_word.codes[3:2]);
      uw <= afs_pkg::ghost(w_word.xvel, c_word.xvel, w_word.codes[3:2]);
      vn <= afs_pkg::ghost(n_word.yvel, c_word.yvel, n_word.codes[5:4]);
      vs <= afs_pkg::ghost(s_word.yvel, c_word.yvel, s_word.codes[5:4]);
    end
    // multiply and combine steps
    if (state == afs_pkg::S_CALC) begin
      prod <= mul_a * mul_b;
      case (kcnt)
        3'd1:    acc <= prod;
        3'd2:    ew <= afs_pkg::sat_val(WW'(rnd));
        3'd3:    acc <= prod;
        3'd4:    ns <= afs_pkg::sat_val(WW'(rnd));
        3'd5:    acc <= prod;
        3'd6:    tsum <= 67'(acc) + 67'(prod);
        3'd7:    res_val <= afs_pkg::sat_val(WW'(c_word.accum) - WW'(half));
        default: ;
      endcase
    end
  end

  // neighbour availability
  assign i_ext    = {1'b0, cur_idx};
  assign i_p1     = i_ext + (IW+1)'(1);
  assign i_pw     = i_ext + (IW+1)'(w_eff);
  assign n_ext    = {1'b0, cell_count};
  assign a_ext    = {1'b0, cur_arr};
  assign interior = (c_word.codes[1:0] == afs_pkg::BC_INTERIOR);
  assign nb_ok    = (col != '0) && (({1'b0, col} + 10'd1) < {1'b0, w_eff}) &&
                    (i_ext >= (IW+1)'(w_eff)) && (i_p1 < n_ext) && (i_p1 < a_ext) &&
                    (i_pw < n_ext) && (i_pw < a_ext);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_index <= cur_idx;
      new_value  <= (interior && nb_ok) ? res_val : '0;
      edge_fault <= interior && !nb_ok;
      last_cell  <= (i_p1 == n_ext);
    end
  end

  // checks
  `AFS_ASSERT_IMP(a_emit_order, 1'b1, emitted_count <= arrived_count)
  `AFS_ASSERT_IMP(a_col_ready, out_load, rem_st.done && !rem_st.busy)
  `AFS_ASSERT_NXT(a_one_emit, accept && emit_go, in_stall && !rem_st.done)

endmodule

// File: sim/advection_flux_stencil_core_tb.sv
// ----------------------------------------------------------------------------
// advection_flux_stencil_core_tb
// self-checking bench for the stencil core: random and directed grid frames,
// a cycle-free predictor of the flux update and an in-order result scoreboard
// ----------------------------------------------------------------------------
module advection_flux_stencil_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BC_ZERO_GRAD = 2'd2;
  localparam logic [1:0] BC_RESERVED  = 2'd3;
  localparam int         STORE_DEPTH  = 1024;
  localparam int         SETTLE_CYC   = 40;

  typedef struct {
    logic              op;
    logic signed [31:0] sv;
    logic [1:0]        sc;
    logic signed [31:0] xv;
    logic [1:0]        xc;
    logic signed [31:0] yv;
    logic [1:0]        yc;
    logic signed [31:0] acc;
  } cell_item_t;

  typedef struct {
    logic [15:0]        idx;
    logic signed [31:0] val;
    logic               fault;
    logic               last;
  } flux_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = afs_pkg::CFG_ROW_WIDTH;
  logic [afs_pkg::SPACE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = afs_pkg::OP_CELL;
  logic signed [31:0] scalar_value = '0;
  logic [1:0] scalar_code = afs_pkg::BC_INTERIOR;
  logic signed [31:0] xvel_value = '0;
  logic [1:0] xvel_code = afs_pkg::BC_INTERIOR;
  logic signed [31:0] yvel_value = '0;
  logic [1:0] yvel_code = afs_pkg::BC_INTERIOR;
  logic signed [31:0] accum_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] cell_index;
  logic signed [31:0] new_value;
  logic edge_fault;
  logic last_cell;

  advection_flux_stencil_core dut (.*);

  always #1 clk = ~clk;

  // pending stimulus, expected results, idling knobs
  cell_item_t   pending_cells[$];
  flux_result_t expected_flux[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;
  int           items_queued = 0;

  // predictor state
  longint      sc_store[STORE_DEPTH];
  longint      xv_store[STORE_DEPTH];
  longint      yv_store[STORE_DEPTH];
  longint      acc_store[STORE_DEPTH];
  logic [5:0]  code_store[STORE_DEPTH];
  int unsigned cells_in;
  int unsigned cells_out;
  int unsigned grid_width;
  int unsigned frame_cells;
  longint      dx_q;
  longint      dy_q;

  function automatic longint clamp_q(longint x);
    longint hi;
    hi = 64'sd2147483647;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint ghost_q(longint nb, longint c, logic [1:0] code);
    if (code == afs_pkg::BC_INTERIOR) return nb;
    if (code == afs_pkg::BC_FIXED) return clamp_q(2 * nb - c);
    return c;
  endfunction

  function automatic int unsigned active_width();
    if (grid_width < 1) return 1;
    if (grid_width > afs_pkg::MAX_ROW - 1) return afs_pkg::MAX_ROW - 1;
    return grid_width;
  endfunction

  // result of cell i from the stored window
  function automatic void flux_for_cell(int unsigned i);
    int unsigned w, col, si, se, sw, sn, ss;
    longint pc, uc, vc, pe, pw, pn, ps, ue, uw, vn, vs, ew, ns, t, res;
    bit ok;
    flux_result_t r;
    w = active_width();
    si = i % STORE_DEPTH;
    res = 0;
    r.fault = 1'b0;
    if (code_store[si][1:0] == afs_pkg::BC_INTERIOR) begin
      col = i % w;
      ok = col > 0 && col + 1 < w && i >= w && i + 1 < frame_cells && i + 1 < cells_in
           && i + w < frame_cells && i + w < cells_in;
      if (!ok) begin
        r.fault = 1'b1;
      end else begin
        se = (i + 1) % STORE_DEPTH;
        sw = (i - 1) % STORE_DEPTH;
        sn = (i + w) % STORE_DEPTH;
        ss = (i - w) % STORE_DEPTH;
        pc = sc_store[si];
        uc = xv_store[si];
        vc = yv_store[si];
        pe = ghost_q(sc_store[se], pc, code_store[se][1:0]);
        pw = ghost_q(sc_store[sw], pc, code_store[sw][1:0]);
        pn = ghost_q(sc_store[sn], pc, code_store[sn][1:0]);
        ps = ghost_q(sc_store[ss], pc, code_store[ss][1:0]);
        ue = ghost_q(xv_store[se], uc, code_store[se][3:2]);
        uw = ghost_q(xv_store[sw], uc, code_store[sw][3:2]);
        vn = ghost_q(yv_store[sn], vc, code_store[sn][5:4]);
        vs = ghost_q(yv_store[ss], vc, code_store[ss][5:4]);
        ew = clamp_q((pe * ue - pw * uw + 32768) >>> 16);
        ns = clamp_q((pn * vn - ps * vs + 32768) >>> 16);
        t = ew * dy_q + ns * dx_q;
        res = clamp_q(acc_store[si] - ((t + 65536) >>> 17));
      end
    end
    r.idx = i[15:0];
    r.val = res[31:0];
    r.last = (i + 1 == frame_cells);
    expected_flux.push_back(r);
    cells_out = (cells_out + 1) & 32'hFFFF;
    if (i + 1 >= frame_cells) begin
      cells_in = 0;
      cells_out = 0;
    end
  endfunction

  function automatic void predict_transaction(cell_item_t c);
    int unsigned s;
    if (cells_out >= frame_cells) begin
      cells_in = 0;
      cells_out = 0;
    end
    if (c.op == afs_pkg::OP_CELL) begin
      if (cells_in >= frame_cells) return;
      s = cells_in % STORE_DEPTH;
      sc_store[s] = 64'(c.sv);
      xv_store[s] = 64'(c.xv);
      yv_store[s] = 64'(c.yv);
      acc_store[s] = 64'(c.acc);
      code_store[s] = {c.yc, c.xc, c.sc};
      cells_in++;
      if (cells_out + active_width() < cells_in) flux_for_cell(cells_out);
    end else if (cells_out < cells_in) begin
      flux_for_cell(cells_out);
    end
  endfunction

  // predictor update on accepted transactions and register writes
  always @(posedge clk) begin
    cell_item_t c;
    if (rst) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        sc_store[k] = 0;
        xv_store[k] = 0;
        yv_store[k] = 0;
        acc_store[k] = 0;
        code_store[k] = '0;
      end
      cells_in = 0;
      cells_out = 0;
      grid_width = 256;
      frame_cells = 65535;
      dx_q = 65536;
      dy_q = 65536;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          afs_pkg::CFG_ROW_WIDTH:  grid_width = 32'(cfg_data[8:0]);
          afs_pkg::CFG_CELL_COUNT: frame_cells = 32'(cfg_data[15:0]);
          afs_pkg::CFG_X_SPACING:  dx_q = 64'(cfg_data);
          afs_pkg::CFG_Y_SPACING:  dy_q = 64'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        c = '{opcode, scalar_value, scalar_code, xvel_value, xvel_code,
              yvel_value, yvel_code, accum_in};
        predict_transaction(c);
      end
    end
  end

  // driver
  always @(posedge clk) begin
    cell_item_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_cells.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        c = pending_cells.pop_front();
        in_valid <= 1'b1;
        opcode <= c.op;
        scalar_value <= c.sv;
        scalar_code <= c.sc;
        xvel_value <= c.xv;
        xvel_code <= c.xc;
        yvel_value <= c.yv;
        yvel_code <= c.yc;
        accum_in <= c.acc;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall and result monitor
  always @(posedge clk) begin
    flux_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_flux.size() == 0) begin
          $error("unexpected result transaction for cell %0d", cell_index);
          mismatches++;
        end else begin
          e = expected_flux.pop_front();
          if (cell_index !== e.idx) begin
            $error("cell_index expected %0d actual %0d", e.idx, cell_index);
            mismatches++;
          end
          if (new_value !== e.val) begin
            $error("new_value expected %0d actual %0d", e.val, new_value);
            mismatches++;
          end
          if (edge_fault !== e.fault) begin
            $error("edge_fault expected %0b actual %0b", e.fault, edge_fault);
            mismatches++;
          end
          if (last_cell !== e.last) begin
            $error("last_cell expected %0b actual %0b", e.last, last_cell);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic logic [1:0] pick_code();
    case ($urandom_range(0, 11))
      8: return afs_pkg::BC_FIXED;
      9: return BC_ZERO_GRAD;
      10: return BC_RESERVED;
      default: return afs_pkg::BC_INTERIOR;
    endcase
  endfunction

  task automatic push_cell(logic op);
    cell_item_t c;
    c = '{op, pick_value(), pick_code(), pick_value(), pick_code(),
          pick_value(), pick_code(), pick_value()};
    pending_cells.push_back(c);
    items_queued++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [afs_pkg::SPACE_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // wait until all stimulus is taken and every result has come back
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_cells.size() != 0 || in_valid || expected_flux.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_grid(int unsigned w, int unsigned n, logic [30:0] dx, logic [30:0] dy);
    write_reg(afs_pkg::CFG_ROW_WIDTH, afs_pkg::SPACE_W'(w));
    write_reg(afs_pkg::CFG_CELL_COUNT, afs_pkg::SPACE_W'(n));
    write_reg(afs_pkg::CFG_X_SPACING, dx);
    write_reg(afs_pkg::CFG_Y_SPACING, dy);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  // stimulus
  initial begin
    int unsigned w, rows, n, mid;
    int phase;
    logic [30:0] dx, dy;
    cell_item_t c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: partial row, then drains flush it, interior cells with faults
    for (int k = 0; k < 5; k++) push_cell(afs_pkg::OP_CELL);
    for (int k = 0; k < 7; k++) push_cell(afs_pkg::OP_DRAIN);
    wait_quiet();

    // small directed grid with extreme values and every boundary code
    set_grid(4, 12, 31'd65536, 31'd65536);
    for (int k = 0; k < 12; k++) begin
      c.op = afs_pkg::OP_CELL;
      c.sv = (k % 3 == 0) ? 32'sh7FFFFFFF : (k % 3 == 1) ? 32'sh80000000 : 32'sh00010000;
      c.xv = (k % 2 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
      c.yv = (k % 2 == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      c.acc = (k % 2 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
      c.sc = (k == 5 || k == 6) ? afs_pkg::BC_INTERIOR : 2'(k % 4);
      c.xc = 2'((k + 1) % 4);
      c.yc = 2'((k + 2) % 4);
      pending_cells.push_back(c);
      items_queued++;
    end
    for (int k = 0; k < 6; k++) push_cell(afs_pkg::OP_DRAIN);
    wait_quiet();

    // empty frame: every cell dropped; widest spacing
    set_grid(0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF);
    for (int k = 0; k < 4; k++) push_cell(afs_pkg::OP_CELL);
    push_cell(afs_pkg::OP_DRAIN);
    wait_quiet();

    // random frames
    phase = 0;
    while (items_queued < 800) begin
      set_idling(phase);
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 1;
        2: w = 511;
        3: w = 3;
        default: w = $urandom_range(3, 9);
      endcase
      rows = $urandom_range(2, 5);
      n = (w == 511) ? $urandom_range(10, 40) : (w < 3 ? 3 : w) * rows;
      if ($urandom_range(0, 3) == 0) n = n - $urandom_range(0, 2);
      case ($urandom_range(0, 4))
        0: dx = '0;
        1: dx = 31'h7FFFFFFF;
        default: dx = 31'($urandom_range(0, 1 << 18));
      endcase
      case ($urandom_range(0, 4))
        0: dy = '0;
        1: dy = 31'h7FFFFFFF;
        default: dy = 31'($urandom_range(0, 1 << 18));
      endcase
      set_grid(w, n, dx, dy);
      mid = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n + 1;
      for (int k = 0; k < n; k++) begin
        push_cell(afs_pkg::OP_CELL);
        if (k == mid) push_cell(afs_pkg::OP_DRAIN);
      end
      // a few cells past a full frame are dropped
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) push_cell(afs_pkg::OP_CELL);
      if ($urandom_range(0, 5) != 0) begin
        repeat (((w == 511) ? n : (w < 3 ? 3 : w)) + 2) push_cell(afs_pkg::OP_DRAIN);
      end
      wait_quiet();
      phase++;
    end

    set_idling(0);
    wait_quiet();
    if (mismatches == 0) begin
      $display("advection_flux_stencil_core_tb: PASS");
    end else begin
      $display("advection_flux_stencil_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("advection_flux_stencil_core_tb: FAIL");
    $finish;
  end

endmodule
